// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CIC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// shared widths, constants and types of the canopy interception block
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int DEPTH_W = 24;
    localparam int FRAC_W  = 17;
    localparam int CELL_W  = 12;
    localparam int LAND_W  = 8;
    localparam int INIT_W  = 11;
    localparam int NET_W   = 25;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [FRAC_W-1:0]  t_frac;

    localparam t_frac Q16_ONE = 17'h10000;

    // room for the request being taken plus three in the front pipeline
    localparam logic [QUEUE_AW:0] QUEUE_LIMIT = 4'(QUEUE_DEPTH - 4);

    // one classified request handed from front to back
    typedef struct packed {
        logic [CELL_W-1:0] idx;
        t_depth            rain;
        t_depth            pet;
        t_depth            cap;
        t_depth            loss;
        logic              paddy;
    } t_item;

    typedef struct packed {
        logic              empty;
        logic [QUEUE_AW:0] count;
    } t_queue_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_back_state;

endpackage

// File: sv/canopy_interception_cell_step.sv
// ----------------------------------------------------------------------------
// canopy_interception_cell_step
// throughput: one request per clock while busy is low, even for the same cell
//   back to back; the rate is set by the store update loop in the back, fed by
//   a single forwarding register and one write / one read port of the store ram
// reset: busy stays high while the written flags are swept
// the receiver cannot stall; each result shows for one cycle only
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module canopy_interception_cell_step
    import cic_pkg::*;
#(
    parameter int CELLS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              start,
    output logic              busy,
    input  logic [CELL_W-1:0] i_cell_index,
    input  t_depth            i_rainfall,
    input  t_depth            i_potential_evap,
    input  t_depth            i_capacity_min,
    input  t_depth            i_capacity_max,
    input  logic [LAND_W-1:0] i_land_use,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  t_frac             i_cfg_data,
    // result side
    output logic              o_valid,
    output t_depth            o_intercepted,
    output logic signed [NET_W-1:0] o_net_rain,
    output t_depth            o_canopy_evap,
    output t_depth            o_store_after
);

    // configuration register indexes
    localparam logic [2:0] CFG_SEASONAL   = 3'd0;
    localparam logic [2:0] CFG_CANAL      = 3'd1;
    localparam logic [2:0] CFG_EMBANKMENT = 3'd2;
    localparam logic [2:0] CFG_INITIAL    = 3'd3;
    localparam logic [2:0] CFG_PADDY      = 3'd4;

    t_frac             r_seasonal_factor;
    t_frac             r_canal_fraction;
    t_frac             r_embankment_fraction;
    logic [INIT_W-1:0] r_initial_store;
    logic [LAND_W-1:0] r_paddy_code;

    logic          accept;
    logic          q_push;
    logic          q_pop;
    t_item         front_item;
    t_item         queue_item;
    t_queue_status q_status;
    t_back_status  back_status;
    logic [NET_W-1:0] net_bits;

    // config writes land directly; values above one are clamped where used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seasonal_factor     <= 17'd65536;
            r_canal_fraction      <= 17'd32768;
            r_embankment_fraction <= 17'd9830;
            r_initial_store       <= 11'd0;
            r_paddy_code          <= 8'd33;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEASONAL:   r_seasonal_factor     <= i_cfg_data;
                CFG_CANAL:      r_canal_fraction      <= i_cfg_data;
                CFG_EMBANKMENT: r_embankment_fraction <= i_cfg_data;
                CFG_INITIAL:    r_initial_store       <= i_cfg_data[INIT_W-1:0];
                CFG_PADDY:      r_paddy_code          <= i_cfg_data[LAND_W-1:0];
                default:        ;
            endcase
        end
    end

    // hold off while sweeping, or when the queue could not take the
    // requests already in the front pipeline plus this one
    assign busy   = back_status.clearing || (q_status.count > QUEUE_LIMIT);
    assign accept = start && !busy;

    // front: index reduction, capacity and paddy loss
    cic_front #(
        .CELLS (CELLS)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (accept),
        .i_cell_index          (i_cell_index),
        .i_rainfall            (i_rainfall),
        .i_potential_evap      (i_potential_evap),
        .i_capacity_min        (i_capacity_min),
        .i_capacity_max        (i_capacity_max),
        .i_land_use            (i_land_use),
        .i_seasonal_factor     (r_seasonal_factor),
        .i_canal_fraction      (r_canal_fraction),
        .i_embankment_fraction (r_embankment_fraction),
        .i_paddy_code          (r_paddy_code),
        .o_valid               (q_push),
        .o_item                (front_item)
    );

    // queue decouples the front from the store pipeline
    cic_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    // back never stalls: it drains one request per cycle
    assign q_pop = !q_status.empty;

    cic_back #(
        .CELLS (CELLS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_pop),
        .i_item          (queue_item),
        .i_initial_store (r_initial_store),
        .o_status        (back_status),
        .o_valid         (o_valid),
        .o_intercepted   (o_intercepted),
        .o_net_rain      (net_bits),
        .o_canopy_evap   (o_canopy_evap),
        .o_store_after   (o_store_after)
    );

    assign o_net_rain = $signed(net_bits);

    // the sweep must keep requests out
    `CIC_ASSERT(a_clear_busy, back_status.clearing, busy, "request possible during sweep")
    // queue never overflows
    `CIC_ASSERT(a_queue_room, q_push && !q_pop, q_status.count < 4'(QUEUE_DEPTH),
        "queue overflow")
    // each popped request gives exactly one strobe, after the b1, b2 and output registers
    `CIC_ASSERT(a_result_timing, 1'b1, o_valid == $past(q_pop, 3), "result strobe misplaced")
    // nothing leaves the queue right after a sweep cycle
    `CIC_ASSERT_NEXT(a_clear_no_pop, back_status.clearing, !q_pop, "pop right after sweep")

endmodule

// File: sv/cic_front.sv
// ----------------------------------------------------------------------------
// cic_front
// three-stage front: cell index reduction, capacity scaling, paddy loss
// ----------------------------------------------------------------------------
module cic_front
    import cic_pkg::*;
#(
    parameter int CELLS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CELL_W-1:0] i_cell_index,
    input  t_depth            i_rainfall,
    input  t_depth            i_potential_evap,
    input  t_depth            i_capacity_min,
    input  t_depth            i_capacity_max,
    input  logic [LAND_W-1:0] i_land_use,
    input  t_frac             i_seasonal_factor,
    input  t_frac             i_canal_fraction,
    input  t_frac             i_embankment_fraction,
    input  logic [LAND_W-1:0] i_paddy_code,
    output logic              o_valid,
    output t_item             o_item
);

    // reciprocal for the index reduction, quotient is exact or one low
    localparam logic [24:0] RECIP   = 25'((32'd1 << 24) / CELLS);
    localparam logic [20:0] CELLS_C = 21'(CELLS);

    function automatic t_frac frac_clamp(input t_frac f);
        return (f > Q16_ONE) ? Q16_ONE : f;
    endfunction

    logic [32:0]       r_ce;
    logic [36:0]       q_prod;
    logic              n_neg;
    t_depth            n_diff;

    logic              r1_valid;
    logic [CELL_W-1:0] r1_x;
    logic [CELL_W-1:0] r1_q;
    t_depth            r1_rain;
    t_depth            r1_pet;
    t_depth            r1_cmin;
    t_depth            r1_diff;
    logic              r1_neg;
    logic [LAND_W-1:0] r1_land;

    logic [32:0]       qc_prod;
    logic [40:0]       sc_prod;
    logic [56:0]       loss_prod;

    logic              r2_valid;
    logic [CELL_W-1:0] r2_x;
    logic [CELL_W-1:0] r2_qc;
    t_depth            r2_rain;
    t_depth            r2_pet;
    t_depth            r2_cmin;
    t_depth            r2_scaled;
    t_depth            r2_loss;
    logic              r2_neg;
    logic [LAND_W-1:0] r2_land;

    logic [CELL_W-1:0] rem;
    logic [CELL_W-1:0] n_idx;
    t_depth            n_cap;

    logic              r3_valid;
    t_item             r3_item;

    // canal times embankment share, at most 2^32
    always_ff @(posedge i_clk) begin
        r_ce <= 33'(34'(frac_clamp(i_canal_fraction)) * 34'(frac_clamp(i_embankment_fraction)));
    end

    // stage 1
    assign q_prod = 37'(i_cell_index) * 37'(RECIP);
    assign n_neg  = i_capacity_max < i_capacity_min;
    assign n_diff = n_neg ? (i_capacity_min - i_capacity_max)
                          : (i_capacity_max - i_capacity_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x    <= i_cell_index;
        r1_q    <= q_prod[35:24];
        r1_rain <= i_rainfall;
        r1_pet  <= i_potential_evap;
        r1_cmin <= i_capacity_min;
        r1_diff <= n_diff;
        r1_neg  <= n_neg;
        r1_land <= i_land_use;
    end

    // stage 2
    assign qc_prod   = 33'(r1_q) * 33'(CELLS_C);
    assign sc_prod   = 41'(r1_diff) * 41'(frac_clamp(i_seasonal_factor));
    assign loss_prod = 57'(r1_rain) * 57'(r_ce);

    always_ff @(posedge i_clk) begin
        r2_x      <= r1_x;
        r2_qc     <= qc_prod[CELL_W-1:0];
        r2_rain   <= r1_rain;
        r2_pet    <= r1_pet;
        r2_cmin   <= r1_cmin;
        r2_scaled <= sc_prod[39:16];
        r2_loss   <= loss_prod[55:32];
        r2_neg    <= r1_neg;
        r2_land   <= r1_land;
    end

    // stage 3
    assign rem   = r2_x - r2_qc;
    assign n_idx = (32'(rem) >= 32'(CELLS)) ? CELL_W'(32'(rem) - 32'(CELLS)) : rem;
    assign n_cap = r2_neg ? (r2_cmin - r2_scaled) : (r2_cmin + r2_scaled);

    always_ff @(posedge i_clk) begin
        r3_item.idx   <= n_idx;
        r3_item.rain  <= r2_rain;
        r3_item.pet   <= r2_pet;
        r3_item.cap   <= n_cap;
        r3_item.loss  <= r2_loss;
        r3_item.paddy <= (r2_land == i_paddy_code);
    end

    assign o_valid = r3_valid;
    assign o_item  = r3_item;

endmodule

// File: sv/cic_queue.sv
// ----------------------------------------------------------------------------
// cic_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module cic_queue
    import cic_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    always_comb begin
        n_count = r_count;
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

// File: sv/cic_back.sv
// ----------------------------------------------------------------------------
// cic_back
// store memory, per-cell update with forwarding, result registers
// ----------------------------------------------------------------------------
module cic_back
    import cic_pkg::*;
#(
    parameter int CELLS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic [INIT_W-1:0] i_initial_store,
    output t_back_status      o_status,
    output logic              o_valid,
    output t_depth            o_intercepted,
    output logic [NET_W-1:0]  o_net_rain,
    output t_depth            o_canopy_evap,
    output t_depth            o_store_after
);

    localparam int            IW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [IW-1:0] LAST = IW'(CELLS - 1);

    // entry: written flag over the store
    logic [DEPTH_W:0] r_mem [CELLS];
    logic [DEPTH_W:0] r_rd_data;

    t_back_state   r_state;
    t_back_state   n_state;
    logic          clearing;
    logic [IW-1:0] r_clr_idx;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [DEPTH_W:0] mem_wd;

    logic          r_b1_valid;
    t_item         r_b1_item;
    logic [IW-1:0] b1_addr;
    logic          b1_hit;
    t_depth        b1_store;
    logic [DEPTH_W:0] b1_sum;
    t_depth        b1_max;
    t_depth        b1_s1;
    t_depth        b1_after;

    logic          r_last_valid;
    logic [IW-1:0] r_last_idx;
    t_depth        r_last_store;

    logic          r_b2_valid;
    t_depth        r_b2_store;
    t_depth        r_b2_s1;
    t_depth        r_b2_after;
    t_depth        r_b2_rain;
    t_depth        r_b2_loss;
    logic          r_b2_paddy;
    t_depth        b2_icpt;
    t_depth        b2_over;
    t_depth        b2_sub;
    logic [NET_W-1:0] n_net;

    logic          r_out_valid;
    t_depth        r_out_icpt;
    logic [NET_W-1:0] r_out_net;
    t_depth        r_out_evap;
    t_depth        r_out_store;

    // clearing sweep state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (r_clr_idx == LAST) n_state = BK_RUN;
            BK_RUN:   n_state = BK_RUN;
            default:  n_state = BK_CLEAR;
        endcase
    end

    always_comb begin
        unique case (r_state)
            BK_CLEAR: clearing = 1'b1;
            BK_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // store update, one cell per cycle; last write forwarded
    assign b1_addr  = IW'(r_b1_item.idx);
    assign b1_hit   = r_last_valid && (r_last_idx == b1_addr);
    assign b1_store = b1_hit ? r_last_store
                    : (r_rd_data[DEPTH_W] ? r_rd_data[DEPTH_W-1:0]
                                          : DEPTH_W'(i_initial_store));
    assign b1_sum   = {1'b0, b1_store} + {1'b0, r_b1_item.rain};
    assign b1_max   = (b1_store > r_b1_item.cap) ? b1_store : r_b1_item.cap;
    assign b1_s1    = (b1_sum < {1'b0, b1_max}) ? b1_sum[DEPTH_W-1:0] : b1_max;
    assign b1_after = (b1_s1 > r_b1_item.pet) ? (b1_s1 - r_b1_item.pet) : '0;

    assign mem_we = clearing || r_b1_valid;
    assign mem_wa = clearing ? r_clr_idx : b1_addr;
    assign mem_wd = clearing ? '0 : {1'b1, b1_after};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[IW'(i_item.idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid   <= 1'b0;
            r_last_valid <= 1'b0;
            r_b2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_b1_valid  <= i_valid && !clearing;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
            if (r_b1_valid) begin
                r_last_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_item <= i_item;
        if (r_b1_valid) begin
            r_last_idx   <= b1_addr;
            r_last_store <= b1_after;
        end
        r_b2_store <= b1_store;
        r_b2_s1    <= b1_s1;
        r_b2_after <= b1_after;
        r_b2_rain  <= r_b1_item.rain;
        r_b2_loss  <= r_b1_item.loss;
        r_b2_paddy <= r_b1_item.paddy;
    end

    // result fields from the registered store values
    assign b2_icpt = r_b2_s1 - r_b2_store;
    assign b2_over = r_b2_rain - b2_icpt;
    assign b2_sub  = ((b2_over != '0) && r_b2_paddy) ? r_b2_loss : '0;
    assign n_net   = {1'b0, b2_over} - {1'b0, b2_sub};

    always_ff @(posedge i_clk) begin
        r_out_icpt  <= b2_icpt;
        r_out_net   <= n_net;
        r_out_evap  <= r_b2_s1 - r_b2_after;
        r_out_store <= r_b2_after;
    end

    assign o_status.clearing = clearing;
    assign o_valid           = r_out_valid;
    assign o_intercepted     = r_out_icpt;
    assign o_net_rain        = r_out_net;
    assign o_canopy_evap     = r_out_evap;
    assign o_store_after     = r_out_store;

endmodule

// File: test/cic_tb_pkg.sv
// ----------------------------------------------------------------------------
// cic_tb_pkg
// register indexes and the per-cell outcome record shared by the testbench
// ----------------------------------------------------------------------------
package cic_tb_pkg;
    import cic_pkg::*;

    localparam int CELL_COUNT = 4096;

    // configuration register map
    typedef enum logic [2:0] {
        REG_SEASONAL   = 3'd0,
        REG_CANAL      = 3'd1,
        REG_EMBANK     = 3'd2,
        REG_INIT_STORE = 3'd3,
        REG_PADDY_CODE = 3'd4
    } t_reg_idx;

    // one cell step outcome, net rain kept as raw two's complement bits
    typedef struct packed {
        t_depth             intercepted;
        logic [NET_W-1:0]   net_rain;
        t_depth             canopy_evap;
        t_depth             store_after;
    } t_cell_outcome;

endpackage

// File: test/cic_checker.sv
// ----------------------------------------------------------------------------
// cic_checker
// watches the request, configuration and result ports of the canopy block,
// predicts each cell step and compares results in order
// ----------------------------------------------------------------------------
module cic_checker
    import cic_pkg::*;
    import cic_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [CELL_W-1:0] i_cell_index,
    input  t_depth            i_rainfall,
    input  t_depth            i_potential_evap,
    input  t_depth            i_capacity_min,
    input  t_depth            i_capacity_max,
    input  logic [LAND_W-1:0] i_land_use,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  t_frac             i_cfg_data,
    input  logic              i_valid,
    input  t_depth            i_intercepted,
    input  logic [NET_W-1:0]  i_net_rain,
    input  t_depth            i_canopy_evap,
    input  t_depth            i_store_after,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint NET_HI = 64'sd16777215;
    localparam longint NET_LO = -64'sd16777216;

    t_frac             seasonal_q;
    t_frac             canal_q;
    t_frac             embank_q;
    logic [INIT_W-1:0] init_store_q;
    logic [LAND_W-1:0] paddy_q;

    t_depth        canopy_mem [CELL_COUNT];
    logic          written_mem [CELL_COUNT];
    t_cell_outcome outcome_q [$];

    int fails;
    int checked;

    initial begin
        fails   = 0;
        checked = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [63:0] frac_limit(input t_frac f);
        return (f > Q16_ONE) ? 64'(Q16_ONE) : 64'(f);
    endfunction

    function automatic logic [63:0] depth_limit(input logic [63:0] v);
        return (v > 64'hFF_FFFF) ? 64'hFF_FFFF : v;
    endfunction

    // one cell step: update the cell's store and return what the block shows
    function automatic t_cell_outcome advance_cell(
        input logic [CELL_W-1:0] cell_id,
        input t_depth            rain,
        input t_depth            pet,
        input t_depth            cmin,
        input t_depth            cmax,
        input logic [LAND_W-1:0] land
    );
        int unsigned   slot;
        logic [63:0]   sf;
        logic [63:0]   water;
        logic [63:0]   cap;
        logic [63:0]   room;
        logic [63:0]   caught;
        logic [63:0]   evap;
        logic [63:0]   loss;
        longint        excess;
        t_cell_outcome res;
        slot  = cell_id % CELL_COUNT;
        sf    = frac_limit(seasonal_q);
        water = written_mem[slot] ? 64'(canopy_mem[slot]) : 64'(init_store_q);

        // scaled span is truncated toward zero, then applied in the span's direction
        if (cmax >= cmin)
            cap = 64'(cmin) + (((64'(cmax) - 64'(cmin)) * sf) >> 16);
        else
            cap = 64'(cmin) - (((64'(cmin) - 64'(cmax)) * sf) >> 16);

        caught = 64'd0;
        excess = 0;
        if (rain != '0) begin
            room = (cap > water) ? cap - water : 64'd0;
            if (room < 64'(rain)) begin
                caught = room;
                excess = longint'(64'(rain) - room);
                if (land == paddy_q) begin
                    loss = (64'(rain) * frac_limit(canal_q) * frac_limit(embank_q)) >> 32;
                    excess = excess - longint'(loss);
                end
            end else begin
                caught = 64'(rain);
            end
            water = depth_limit(water + caught);
        end

        evap  = (water < 64'(pet)) ? water : 64'(pet);
        water = water - evap;
        canopy_mem[slot]  = water[DEPTH_W-1:0];
        written_mem[slot] = 1'b1;

        if (excess > NET_HI) excess = NET_HI;
        if (excess < NET_LO) excess = NET_LO;

        res.intercepted = depth_limit(caught);
        res.net_rain    = excess[NET_W-1:0];
        res.canopy_evap = depth_limit(evap);
        res.store_after = depth_limit(water);
        return res;
    endfunction

    task automatic report_field(input string field, input longint want, input longint got);
        fails = fails + 1;
        if (fails <= 30)
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_cell_outcome want;
        if (!i_rst_n) begin
            seasonal_q   <= Q16_ONE;
            canal_q      <= t_frac'(32768);
            embank_q     <= t_frac'(9830);
            init_store_q <= '0;
            paddy_q      <= LAND_W'(33);
            for (int c = 0; c < CELL_COUNT; c++)
                written_mem[c] = 1'b0;
            outcome_q.delete();
        end else begin
            // results first: a result is always older than a request taken now
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 30)
                        $display("[%0t] result with nothing expected: intercepted %0d",
                                 $time, i_intercepted);
                end else begin
                    want = outcome_q.pop_front();
                    checked = checked + 1;
                    if (i_intercepted !== want.intercepted)
                        report_field("intercepted", want.intercepted, i_intercepted);
                    if (i_net_rain !== want.net_rain)
                        report_field("net_rain", $signed(want.net_rain), $signed(i_net_rain));
                    if (i_canopy_evap !== want.canopy_evap)
                        report_field("canopy_evap", want.canopy_evap, i_canopy_evap);
                    if (i_store_after !== want.store_after)
                        report_field("store_after", want.store_after, i_store_after);
                end
            end

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SEASONAL:   seasonal_q   <= i_cfg_data;
                    REG_CANAL:      canal_q      <= i_cfg_data;
                    REG_EMBANK:     embank_q     <= i_cfg_data;
                    REG_INIT_STORE: init_store_q <= i_cfg_data[INIT_W-1:0];
                    REG_PADDY_CODE: paddy_q      <= i_cfg_data[LAND_W-1:0];
                    default: ;
                endcase
            end

            if (i_start && !i_busy)
                outcome_q.push_back(advance_cell(i_cell_index, i_rainfall, i_potential_evap,
                                                 i_capacity_min, i_capacity_max, i_land_use));
        end
        o_fail_count <= fails;
        o_pending    <= outcome_q.size();
        o_checked    <= checked;
    end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives cell step requests and register writes into the canopy interception
// block; a directed set covers field extremes and the special cases, then
// random bursts run under several register settings while cic_checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import cic_pkg::*;
    import cic_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no request or result taken before the run is called hung;
    // covers the written-flag sweep after reset with plenty of margin
    localparam int IDLE_LIMIT   = 12000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 180;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CELL_W-1:0] i_cell_index;
    t_depth            i_rainfall;
    t_depth            i_potential_evap;
    t_depth            i_capacity_min;
    t_depth            i_capacity_max;
    logic [LAND_W-1:0] i_land_use;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    t_frac             i_cfg_data;
    logic              o_valid;
    t_depth            o_intercepted;
    logic signed [NET_W-1:0] o_net_rain;
    t_depth            o_canopy_evap;
    t_depth            o_store_after;

    int fail_count;
    int pending;
    int checked;

    // testbench copy of the paddy code, used to aim land use at paddy cells
    logic [LAND_W-1:0] paddy_now;
    int sent;
    int paddy_sent;
    int idle_cycles;

    canopy_interception_cell_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cell_index     (i_cell_index),
        .i_rainfall       (i_rainfall),
        .i_potential_evap (i_potential_evap),
        .i_capacity_min   (i_capacity_min),
        .i_capacity_max   (i_capacity_max),
        .i_land_use       (i_land_use),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_intercepted    (o_intercepted),
        .o_net_rain       (o_net_rain),
        .o_canopy_evap    (o_canopy_evap),
        .o_store_after    (o_store_after)
    );

    cic_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_cell_index     (i_cell_index),
        .i_rainfall       (i_rainfall),
        .i_potential_evap (i_potential_evap),
        .i_capacity_min   (i_capacity_min),
        .i_capacity_max   (i_capacity_max),
        .i_land_use       (i_land_use),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (o_valid),
        .i_intercepted    (o_intercepted),
        .i_net_rain       (o_net_rain),
        .i_canopy_evap    (o_canopy_evap),
        .i_store_after    (o_store_after),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog: any accepted request or result restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request; returns at the edge that takes it, start still high
    task automatic send_request(
        input logic [CELL_W-1:0] cell_id,
        input t_depth            rain,
        input t_depth            pet,
        input t_depth            cmin,
        input t_depth            cmax,
        input logic [LAND_W-1:0] land
    );
        start            <= 1'b1;
        i_cell_index     <= cell_id;
        i_rainfall       <= rain;
        i_potential_evap <= pet;
        i_capacity_min   <= cmin;
        i_capacity_max   <= cmax;
        i_land_use       <= land;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent = sent + 1;
        if (land == paddy_now) paddy_sent = paddy_sent + 1;
    endtask

    // register write: one cycle with the enable high, then low again
    task automatic write_reg(input t_reg_idx reg_sel, input t_frac value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= reg_sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_settings(
        input t_frac             seasonal,
        input t_frac             canal,
        input t_frac             embank,
        input logic [INIT_W-1:0] init_store,
        input logic [LAND_W-1:0] paddy
    );
        write_reg(REG_SEASONAL, seasonal);
        write_reg(REG_CANAL, canal);
        write_reg(REG_EMBANK, embank);
        write_reg(REG_INIT_STORE, t_frac'(init_store));
        write_reg(REG_PADDY_CODE, t_frac'(paddy));
        paddy_now = paddy;
    endtask

    // drop start, then wait so the pending count reflects the last request taken
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_depth any_depth();
        return t_depth'($urandom);
    endfunction

    // random request, mostly on a small set of cells so stores build up,
    // with rain sized against capacity so both fits and overflows happen
    task automatic send_random_request();
        logic [CELL_W-1:0] cell_id;
        t_depth            rain;
        t_depth            pet;
        t_depth            cmin;
        t_depth            cmax;
        logic [LAND_W-1:0] land;
        int                pick;

        pick = $urandom_range(0, 99);
        if (pick < 70)      cell_id = CELL_W'($urandom_range(0, 31));
        else if (pick < 90) cell_id = CELL_W'($urandom);
        else                cell_id = ($urandom_range(0, 1) != 0) ? '1 : '0;

        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            cmin = t_depth'($urandom_range(0, 20000));
            cmax = t_depth'($urandom_range(0, 40000));
        end else if (pick < 80) begin
            cmin = any_depth();
            cmax = any_depth();
        end else if (pick < 90) begin
            cmin = t_depth'($urandom_range(0, 30000));
            cmax = cmin;
        end else begin
            cmin = ($urandom_range(0, 1) != 0) ? '1 : '0;
            cmax = ($urandom_range(0, 1) != 0) ? '1 : any_depth();
        end

        pick = $urandom_range(0, 99);
        if (pick < 15)      rain = '0;
        else if (pick < 65) rain = t_depth'($urandom_range(1, 30000));
        else if (pick < 85) rain = any_depth();
        else                rain = '1;

        pick = $urandom_range(0, 99);
        if (pick < 40)      pet = t_depth'($urandom_range(0, 2000));
        else if (pick < 60) pet = '0;
        else if (pick < 90) pet = any_depth();
        else                pet = '1;

        land = ($urandom_range(0, 99) < 40) ? paddy_now : LAND_W'($urandom);

        send_request(cell_id, rain, pet, cmin, cmax, land);
    endtask

    initial begin
        int phase;
        int done;
        int burst;
        int gap;
        t_frac seasonal;
        t_frac canal;
        t_frac embank;

        // every input known from time zero
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_cell_index     <= '0;
        i_rainfall       <= '0;
        i_potential_evap <= '0;
        i_capacity_min   <= '0;
        i_capacity_max   <= '0;
        i_land_use       <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        idle_cycles      <= 0;
        paddy_now  = LAND_W'(33);
        sent       = 0;
        paddy_sent = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // written-flag sweep runs with busy high
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // directed, part one: full fractions, an initial store of 1024
        apply_settings(Q16_ONE, Q16_ONE, Q16_ONE, INIT_W'(1024), LAND_W'(33));
        // untouched cell, no rain, no evaporation
        send_request('0, '0, '0, '0, '0, '0);
        // untouched cell, rain, evaporation and capacity max at full scale, paddy: net rain goes negative
        send_request('1, '1, '1, '0, '1, LAND_W'(33));
        // max below min
        send_request(CELL_W'(1), t_depth'(1000), '0, '1, '0, LAND_W'(7));
        // rain fits in the space, then overflows on a paddy cell, then dries out
        send_request(CELL_W'(2), t_depth'(2000), t_depth'(100), t_depth'(5000),
                     t_depth'(9000), LAND_W'(7));
        send_request(CELL_W'(2), t_depth'(10000), '0, t_depth'(5000),
                     t_depth'(9000), LAND_W'(33));
        send_request(CELL_W'(2), '0, t_depth'(24'h80_0000), t_depth'(5000),
                     t_depth'(9000), LAND_W'(33));
        // all fields at their top value
        send_request(CELL_W'(3), '1, '1, '1, '1, '1);
        // equal bounds, rain just above the space left
        send_request(CELL_W'(5), t_depth'(7000), t_depth'(1), t_depth'(8000),
                     t_depth'(8000), LAND_W'(0));
        // store already above capacity: nothing intercepted
        send_request(CELL_W'(6), t_depth'(500), '0, t_depth'(100), t_depth'(200),
                     LAND_W'(33));
        send_request(CELL_W'(0), t_depth'(1), '0, t_depth'(4000), '1, LAND_W'(33));
        wait_drained();

        // directed, part two: fractions above one, top initial store and paddy code
        apply_settings(t_frac'(17'h1FFFF), t_frac'(17'h1FFFF), t_frac'(17'h1FFFF),
                       INIT_W'(2047), LAND_W'(255));
        send_request(CELL_W'(7), '1, '0, t_depth'(100), '1, LAND_W'(255));
        send_request(CELL_W'(8), t_depth'(3000), t_depth'(50000), '1, t_depth'(100),
                     LAND_W'(255));
        send_request(CELL_W'(4095), t_depth'(20000), '1, t_depth'(1000), t_depth'(9000),
                     LAND_W'(254));
        wait_drained();
        apply_settings('0, '0, '0, '0, '0);
        send_request(CELL_W'(9), t_depth'(9000), '0, t_depth'(300), '1, LAND_W'(0));
        send_request(CELL_W'(9), '1, '0, t_depth'(300), '1, LAND_W'(0));
        send_request(CELL_W'(10), t_depth'(1), t_depth'(1), '0, '0, LAND_W'(1));
        wait_drained();

        // random phases: reset values, top extremes, zeros, then random settings
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(Q16_ONE, t_frac'(32768), t_frac'(9830), '0, LAND_W'(33));
                1: apply_settings('1, '1, '1, '1, '1);
                2: apply_settings('0, '0, '0, '0, '0);
                default: begin
                    seasonal = t_frac'($urandom_range(0, 65536));
                    canal    = ($urandom_range(0, 3) == 0) ? t_frac'($urandom)
                                                           : t_frac'($urandom_range(0, 65536));
                    embank   = t_frac'($urandom_range(0, 65536));
                    apply_settings(seasonal, canal, embank, INIT_W'($urandom),
                                   LAND_W'($urandom));
                end
            endcase

            done = 0;
            while (done < PHASE_ITEMS) begin
                // bursts of back-to-back requests, occasionally long ones
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
                for (int b = 0; b < burst && done < PHASE_ITEMS; b++) begin
                    send_random_request();
                    done++;
                end
                gap = $urandom_range(1, 9);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d on paddy cells) over %0d register settings",
                 sent, paddy_sent, PHASES + 3);
        $display("%0d results compared, %0d mismatches, %0d left unanswered",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: canopy_interception_cell_step.f
+incdir+sv
sv/cic_pkg.sv
sv/cic_front.sv
sv/cic_queue.sv
sv/cic_back.sv
sv/canopy_interception_cell_step.sv
test/cic_tb_pkg.sv
test/cic_checker.sv
test/tb_top.sv
